>>> sv/vtbm_pkg.sv
// Package for the volume table block mapper.
// Holds the operation and status codes, the table entry layout and the control structs.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package vtbm_pkg;

    localparam int SUM_W = 17;
    localparam int CYL_W = 13;
    localparam int COUNT_OUT_W = 4;
    localparam logic [CYL_W-1:0] CYL_LIMIT = 13'd8191;

    typedef enum logic [1:0] {
        FUNC_TRANSLATE = 2'd0,
        FUNC_CREATE    = 2'd1,
        FUNC_DELETE    = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NO_VOLUME = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]  volume_kind;
        logic [15:0] sector_count;
        logic [3:0]  start_sector;
        logic [9:0]  start_cylinder;
    } entry_t;

    typedef struct packed {
        logic load_new;
        logic shift_in;
        logic clear;
    } cell_ctrl_t;

    typedef struct packed {
        logic                   translate;
        logic [9:0]             start_cylinder;
        status_t                status;
        logic [COUNT_OUT_W-1:0] volume_count;
    } xlat_side_t;

endpackage

`default_nettype wire

>>> sv/vtbm_cell.sv
// One cell of the volume table: holds a single entry.
// Loads a new entry, takes its upper neighbor's entry on a delete, or clears; uses vtbm_pkg.
`default_nettype none

module vtbm_cell
    import vtbm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire entry_t     new_entry,
    input  wire entry_t     upper_entry,
    output entry_t          entry
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load_new)
        begin
            entry_next = new_entry;
        end
        else if (ctrl.shift_in)
        begin
            entry_next = upper_entry;
        end
        else if (ctrl.clear)
        begin
            entry_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

>>> sv/vtbm_divmod.sv
// Translation pipeline: splits a sector sum into cylinder and sector by a constant divisor.
// Reciprocal multiply, back multiply, then one correction step; uses vtbm_pkg.
`default_nettype none

module vtbm_divmod
    import vtbm_pkg::*;
#(
    parameter int DIVISOR = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire logic [SUM_W-1:0]       sum,
    input  wire xlat_side_t             side_in,
    output logic                        out_valid,
    output logic [CYL_W-1:0]            phys_cylinder,
    output logic [3:0]                  phys_sector,
    output status_t                     status,
    output logic [COUNT_OUT_W-1:0]      volume_count
);

    localparam int RECIP = (1 << SUM_W) / DIVISOR;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W = SUM_W + RECIP_W;
    localparam int CSUM_W = SUM_W + 1;
    localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);
    localparam logic [SUM_W-1:0] DIVISOR_V = SUM_W'(DIVISOR);

    logic                   v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic [SUM_W-1:0]       s1_reg, s2_reg, s3_reg;
    logic [SUM_W-1:0]       q2_reg, q3_reg;
    logic [SUM_W-1:0]       back3_reg;
    xlat_side_t             side1_reg, side2_reg, side3_reg;
    logic [CYL_W-1:0]       cyl_reg;
    logic [3:0]             sec_reg;
    status_t                status_reg;
    logic [COUNT_OUT_W-1:0] count_reg;

    logic [PROD_W-1:0]      recip_prod;
    logic [SUM_W-1:0]       rem_raw;
    logic                   rem_ge;
    logic [SUM_W-1:0]       rem_fix;
    logic [CSUM_W-1:0]      cyl_sum;
    logic [CYL_W-1:0]       cyl_next;
    logic [3:0]             sec_next;

    always_comb
    begin
        recip_prod = PROD_W'(s1_reg) * PROD_W'(RECIP_V);
        rem_raw = s3_reg - back3_reg;
        rem_ge = (rem_raw >= DIVISOR_V);
        rem_fix = rem_ge ? (rem_raw - DIVISOR_V) : rem_raw;
        cyl_sum = CSUM_W'(side3_reg.start_cylinder) + CSUM_W'(q3_reg) + CSUM_W'(rem_ge);
        cyl_next = (cyl_sum > CSUM_W'(CYL_LIMIT)) ? CYL_LIMIT : CYL_W'(cyl_sum);
        sec_next = 4'(rem_fix);
        if (!side3_reg.translate)
        begin
            cyl_next = '0;
            sec_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= sum;
            side1_reg <= side_in;
            s2_reg <= s1_reg;
            q2_reg <= SUM_W'(recip_prod >> SUM_W);
            side2_reg <= side1_reg;
            s3_reg <= s2_reg;
            q3_reg <= q2_reg;
            back3_reg <= SUM_W'(q2_reg * DIVISOR_V);
            side3_reg <= side2_reg;
            cyl_reg <= cyl_next;
            sec_reg <= sec_next;
            status_reg <= side3_reg.status;
            count_reg <= side3_reg.volume_count;
        end
    end

    assign out_valid = out_valid_reg;
    assign phys_cylinder = cyl_reg;
    assign phys_sector = sec_reg;
    assign status = status_reg;
    assign volume_count = count_reg;

endmodule

`default_nettype wire

>>> sv/volume_table_block_mapper.sv
// Top level of the volume table block mapper: table of volume cells and translation pipeline.
// Instantiates vtbm_cell and vtbm_divmod; uses vtbm_pkg.
// Depends on vtbm_pkg, vtbm_cell and vtbm_divmod.
`default_nettype none

// The block takes one transaction per cycle while m_axis_tready does not stall it, and returns
// one result per transaction, in order, through the translation pipeline: sector sum,
// reciprocal multiply, back multiply, then correction and cylinder add.
// The table lives in a row of MAX_VOLUMES cells; create and delete update it in the cycle
// of acceptance, a delete moving every later live entry down one cell at once. The table
// is zero right after reset, with no clearing pass.
module volume_table_block_mapper
    import vtbm_pkg::*;
#(
    parameter int MAX_VOLUMES = 8,
    parameter int SECTORS_PER_CYL = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: volume_slot[2:0], block_number[18:3], start_cylinder[28:19],
    // start_sector[32:29], sector_count[48:33], volume_kind[50:49], zero fill.
    input  wire logic [55:0] s_axis_tdata,
    // tuser: func[1:0].
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: phys_cylinder[12:0], phys_sector[16:13], status[18:17],
    // volume_count[22:19], zero fill.
    output logic [23:0]      m_axis_tdata
);

    localparam int CNT_W = $clog2(MAX_VOLUMES + 1);

    logic [1:0]             func;
    logic [2:0]             volume_slot;
    logic [15:0]            block_number;
    entry_t                 new_entry;

    logic                   advance;
    logic                   accept;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   table_full;
    logic                   slot_live;
    logic                   do_create;
    logic                   do_delete;
    status_t                status_in;
    entry_t                 sel_entry;
    logic [SUM_W-1:0]       sum;
    xlat_side_t             side_in;

    entry_t                 entries [MAX_VOLUMES];
    entry_t                 uppers [MAX_VOLUMES];
    cell_ctrl_t             ctrls [MAX_VOLUMES];

    logic                   out_valid;
    logic [CYL_W-1:0]       phys_cylinder;
    logic [3:0]             phys_sector;
    status_t                status;
    logic [COUNT_OUT_W-1:0] volume_count;

    assign func = s_axis_tuser;
    assign volume_slot = s_axis_tdata[2:0];
    assign block_number = s_axis_tdata[18:3];
    assign new_entry.start_cylinder = s_axis_tdata[28:19];
    assign new_entry.start_sector = s_axis_tdata[32:29];
    assign new_entry.sector_count = s_axis_tdata[48:33];
    assign new_entry.volume_kind = s_axis_tdata[50:49];

    assign advance = !out_valid || m_axis_tready;
    assign s_axis_tready = advance;
    assign accept = s_axis_tvalid && advance;

    always_comb
    begin
        table_full = (count_reg == CNT_W'(MAX_VOLUMES));
        slot_live = (8'(volume_slot) < 8'(count_reg));
        do_create = accept && (func == FUNC_CREATE) && !table_full;
        do_delete = accept && (func == FUNC_DELETE) && slot_live;
        count_next = count_reg;
        status_in = STATUS_OK;
        case (func)
            FUNC_CREATE:
            begin
                if (table_full)
                begin
                    status_in = STATUS_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            FUNC_DELETE:
            begin
                if (!slot_live)
                begin
                    status_in = STATUS_NO_VOLUME;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_comb
    begin
        sel_entry = '0;
        for (int i = 0; i < MAX_VOLUMES; i++)
        begin
            if (8'(volume_slot) == 8'(i))
            begin
                sel_entry = entries[i];
            end
        end
        sum = SUM_W'(sel_entry.start_sector) + SUM_W'(block_number);
        side_in.translate = (func == FUNC_TRANSLATE);
        side_in.start_cylinder = sel_entry.start_cylinder;
        side_in.status = status_in;
        side_in.volume_count = COUNT_OUT_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    for (genvar i = 0; i < MAX_VOLUMES; i++)
    begin : g_cell
        if (i + 1 < MAX_VOLUMES)
        begin : g_upper
            assign uppers[i] = entries[i+1];
        end
        else
        begin : g_top
            assign uppers[i] = '0;
        end

        assign ctrls[i].load_new = do_create && (count_reg == CNT_W'(i));
        assign ctrls[i].shift_in = do_delete && (8'(i) >= 8'(volume_slot))
                                   && (CNT_W'(i + 1) < count_reg);
        assign ctrls[i].clear = do_delete && (count_reg == CNT_W'(i + 1));

        vtbm_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrls[i]),
            .new_entry   (new_entry),
            .upper_entry (uppers[i]),
            .entry       (entries[i])
        );
    end

    vtbm_divmod #(
        .DIVISOR (SECTORS_PER_CYL)
    ) u_divmod (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (advance),
        .in_valid      (accept),
        .sum           (sum),
        .side_in       (side_in),
        .out_valid     (out_valid),
        .phys_cylinder (phys_cylinder),
        .phys_sector   (phys_sector),
        .status        (status),
        .volume_count  (volume_count)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata = {1'b0, volume_count, status, phys_sector, phys_cylinder};

    for (genvar i = 0; i < MAX_VOLUMES; i++)
    begin : g_vacant_check
        vacant_cell_zero: assert property (@(posedge clk) disable iff (!rst_n)
            (CNT_W'(i) >= count_reg) |-> (entries[i] == '0))
            else $error("Cell above the live count holds a nonzero entry.");
    end

    count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_VOLUMES))
        else $error("Volume count exceeds the table size.");

    create_increments: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (func == FUNC_CREATE) && !table_full)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("Create did not add one volume.");

    translate_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (func == FUNC_TRANSLATE)) |=> $stable(count_reg))
        else $error("Translate changed the volume count.");

    delete_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (func == FUNC_DELETE) && slot_live)
        |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("Delete did not remove one volume.");

endmodule

`default_nettype wire
